// File: rtl/lz77_marker_byte_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// LZ77 marker byte decoder assertion macros
// Concurrent checks on the core clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef LZ77_MARKER_BYTE_DECODER_CORE_MACROS_SVH
`define LZ77_MARKER_BYTE_DECODER_CORE_MACROS_SVH

// check a property at every rising clock edge
`define LZMBD_CHECK(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("lzmbd check failed");

// check that cond is followed by expr in the next cycle
`define LZMBD_CHECK_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("lzmbd sequence check failed");

`endif

// File: rtl/lzmbd_pkg.sv
// ----------------------------------------------------------------------------
// lzmbd_pkg
// Shared constants, codes and the token command type of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzmbd_pkg;

   localparam int WINDOW_SIZE = 4096;
   localparam int MAX_MATCH   = 64;

   localparam int PTR_W = $clog2(WINDOW_SIZE);
   localparam int CNT_W = PTR_W + 1;
   localparam int OFF_W = CNT_W;
   localparam int LEN_W = 8;
   localparam int RUN_W = $clog2(MAX_MATCH + 1);

   localparam logic [LEN_W-1:0] LEN_CAP = 8'd255;
   localparam logic [OFF_W-1:0] OFF_CAP = OFF_W'(2 * WINDOW_SIZE - 1);

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_OFF = 2'd1;
   localparam logic [1:0] STAT_LONG    = 2'd2;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_EMIT  = 2'd1;
   localparam logic [1:0] CMD_ERROR = 2'd2;
   localparam logic [1:0] CMD_COPY  = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [1:0]       status;
      logic [7:0]       data;
      logic [RUN_W-1:0] run_len;
      logic [PTR_W-1:0] offset;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/lzmbd_ram.sv
// ----------------------------------------------------------------------------
// lzmbd_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lzmbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lzmbd_parse.sv
// ----------------------------------------------------------------------------
// lzmbd_parse
// Token parser: marker, escape, varint length and offset, match checks.
// ----------------------------------------------------------------------------
`default_nettype none

module lzmbd_parse import lzmbd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   input  wire logic             block_start,
   input  wire logic [CNT_W-1:0] produced,
   output cmd_type               cmd
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LIT  = 3'd1;
   localparam logic [2:0] PH_MARK = 3'd2;
   localparam logic [2:0] PH_LEN  = 3'd3;
   localparam logic [2:0] PH_OFF  = 3'd4;

   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       marker_ff, marker_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [OFF_W-1:0] off_ff, off_in;

   logic [LEN_W+6:0] len_shift;
   logic [OFF_W+6:0] off_shift;
   logic [LEN_W-1:0] len_sat;
   logic [OFF_W-1:0] off_sat;
   logic             bad_off;

   assign len_shift = {len_ff, in_byte[6:0]};
   assign off_shift = {off_ff, in_byte[6:0]};
   assign len_sat   = (len_shift > (LEN_W+7)'(LEN_CAP)) ? LEN_CAP : len_shift[LEN_W-1:0];
   assign off_sat   = (off_shift > (OFF_W+7)'(OFF_CAP)) ? OFF_CAP : off_shift[OFF_W-1:0];
   assign bad_off   = (off_sat == '0) || (off_sat > OFF_W'(WINDOW_SIZE)) ||
                      (off_sat > produced);

   always_comb begin
      phase_in    = phase_ff;
      marker_in   = marker_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      cmd.kind    = CMD_NONE;
      cmd.status  = STAT_OK;
      cmd.data    = in_byte;
      cmd.run_len = len_ff[RUN_W-1:0];
      cmd.offset  = off_sat[PTR_W-1:0];
      if (block_start) begin
         marker_in = in_byte;
         len_in    = '0;
         off_in    = '0;
         phase_in  = PH_LIT;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_LIT: begin
               if (in_byte == marker_ff) begin
                  phase_in = PH_MARK;
               end else begin
                  cmd.kind = CMD_EMIT;
               end
            end
            PH_MARK: begin
               if (in_byte == 8'd0) begin
                  cmd.kind = CMD_EMIT;
                  cmd.data = marker_ff;
                  phase_in = PH_LIT;
               end else begin
                  len_in   = {1'b0, in_byte[6:0]};
                  off_in   = '0;
                  phase_in = in_byte[7] ? PH_LEN : PH_OFF;
               end
            end
            PH_LEN: begin
               len_in = len_sat;
               if (!in_byte[7]) begin
                  phase_in = PH_OFF;
               end
            end
            PH_OFF: begin
               off_in = off_sat;
               if (!in_byte[7]) begin
                  phase_in = PH_LIT;
                  cmd.data = 8'd0;
                  if (bad_off) begin
                     cmd.kind   = CMD_ERROR;
                     cmd.status = STAT_BAD_OFF;
                  end else if (len_ff > LEN_W'(MAX_MATCH)) begin
                     cmd.kind   = CMD_ERROR;
                     cmd.status = STAT_LONG;
                  end else if (len_ff != '0) begin
                     cmd.kind = CMD_COPY;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         marker_ff <= '0;
         len_ff    <= '0;
         off_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         marker_ff <= marker_in;
         len_ff    <= len_in;
         off_ff    <= off_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lz77_marker_byte_decoder_core.sv
// ----------------------------------------------------------------------------
// lz77_marker_byte_decoder_core: LZ77 marker byte decoder, one byte per item.
// Literal, escape and error: result registered the cycle after accept; next byte taken when output is free.
// Match copy: per byte a ring RAM read, then write and output (stalls until output is free).
// Reset: synchronous, clears control state; history ring needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lz77_marker_byte_decoder_core_macros.svh"

module lz77_marker_byte_decoder_core import lzmbd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // [7:0] in_byte
   input  wire logic       req_tuser,  // [0] block_start
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // [7:0] out_byte
   output logic            rsp_tlast,
   output logic [1:0]      rsp_tuser   // [1:0] status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] produced_ff, produced_in, produced_inc;
   logic [RUN_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] off_ff, off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [1:0]       rsp_user_ff, rsp_user_in;

   logic             accept;
   logic             slot_free;
   cmd_type          cmd;
   logic             wr_en, rd_en;
   logic [7:0]       wr_data, rd_data;
   logic [PTR_W-1:0] rd_addr;

   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == ST_IDLE) && slot_free;
   assign accept       = req_tvalid && req_tready;
   assign rd_addr      = wp_ff - off_ff;
   assign produced_inc = (produced_ff < CNT_W'(WINDOW_SIZE)) ?
                         produced_ff + CNT_W'(1) : produced_ff;

   lzmbd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .block_start (req_tuser),
      .produced    (produced_ff),
      .cmd         (cmd)
   );

   lzmbd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_SIZE)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      produced_in  = produced_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_data      = cmd.data;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  produced_in = '0;
               end
               case (cmd.kind)
                  CMD_EMIT: begin
                     wr_en        = 1'b1;
                     wp_in        = wp_ff + PTR_W'(1);
                     produced_in  = produced_inc;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = cmd.data;
                     rsp_last_in  = 1'b1;
                     rsp_user_in  = STAT_OK;
                  end
                  CMD_ERROR: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = 8'd0;
                     rsp_last_in  = 1'b1;
                     rsp_user_in  = cmd.status;
                  end
                  CMD_COPY: begin
                     cnt_in   = cmd.run_len;
                     off_in   = cmd.offset;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (slot_free) begin
               wr_en        = 1'b1;
               wr_data      = rd_data;
               wp_in        = wp_ff + PTR_W'(1);
               produced_in  = produced_inc;
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data;
               rsp_last_in  = (cnt_ff == RUN_W'(1));
               rsp_user_in  = STAT_OK;
               cnt_in       = cnt_ff - RUN_W'(1);
               state_in     = (cnt_ff == RUN_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         produced_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         produced_ff  <= produced_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   `LZMBD_CHECK(a_busy_not_ready, (state_ff != ST_IDLE) |-> !req_tready)
   `LZMBD_CHECK(a_copy_count_live, (state_ff != ST_IDLE) |-> (cnt_ff != '0))
   `LZMBD_CHECK(a_produced_bound, produced_ff <= CNT_W'(WINDOW_SIZE))
   `LZMBD_CHECK(a_error_shape, (rsp_tvalid && rsp_tuser != STAT_OK) |-> (rsp_tdata == 8'd0 && rsp_tlast))
   `LZMBD_CHECK_NEXT(a_read_then_write, state_ff == ST_READ, state_ff == ST_WRITE)

endmodule

`default_nettype wire
